### rtl/core/art_pkg.sv
// ----------------------------------------------------------------------------
// art_pkg: address range table shared definitions
// Transfer types, status and command codes and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none

package art_pkg;

  // parameter defaults
  localparam int DEF_MAX_RANGES = 16;
  localparam int DEF_ADDR_WIDTH = 32;

  // fixed field widths of the transfers
  localparam int FIELD_W = 32;
  localparam int IDX_W   = 4;
  localparam int ST_W    = 2;

  // command codes
  localparam logic CMD_LOOKUP = 1'b0;
  localparam logic CMD_INSERT = 1'b1;

  // status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL = 2'd3;

  // input transfer
  typedef struct packed {
    logic               command;
    logic [FIELD_W-1:0] address;
    logic [FIELD_W-1:0] length;
  } in_item_t;

  // result transfer
  typedef struct packed {
    logic [ST_W-1:0]    status;
    logic [IDX_W-1:0]   entry_index;
    logic [FIELD_W-1:0] entry_base;
    logic [FIELD_W-1:0] entry_length;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/core/art_ram.sv
// ----------------------------------------------------------------------------
// art_ram: range table storage
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module art_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/core/address_range_table_core.sv
// ----------------------------------------------------------------------------
// address_range_table_core: sorted address range table with last-hit hint
// Lookup: k entries scanned (1..count), starting at the hint; an empty table
//   answers without a scan.
// Insert: count entries scanned when appended at the end, and when placed at
//   sorted position p < count (p + 1 entries scanned, count - p entries shifted);
//   the scan and shift loops both run one table entry per cycle through the
//   single RAM read port.
// One item at a time; a new item is taken while the last result waits.
// Synchronous active-low reset clears count, hint and handshake state; the
// table RAM is not cleared, only entries below the count are used.
// ----------------------------------------------------------------------------
`default_nettype none

module address_range_table_core
  import art_pkg::*;
#(
  parameter int MAX_RANGES = DEF_MAX_RANGES,
  parameter int ADDR_WIDTH = DEF_ADDR_WIDTH
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);

  localparam int  DW        = (ADDR_WIDTH > FIELD_W) ? FIELD_W : ADDR_WIDTH;
  localparam bit  TOP_CHECK = (ADDR_WIDTH <= FIELD_W);
  localparam int  IW        = $clog2(MAX_RANGES);
  localparam int  CW        = $clog2(MAX_RANGES + 1);

  // state codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_LOOK  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_WRITE = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]      state_r, state_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   last_hit_r, last_hit_nxt;
  logic [IW-1:0]   cur_r, cur_nxt;
  logic [IW-1:0]   pos_r, pos_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  logic [DW-1:0]   a_r, a_nxt;
  logic [DW-1:0]   len_r, len_nxt;
  out_item_t       res_r, res_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;

  // table RAM ports
  logic            ram_we;
  logic [IW-1:0]   ram_waddr;
  logic [2*DW-1:0] ram_wdata;
  logic [IW-1:0]   ram_raddr;
  logic [2*DW-1:0] ram_q;

  art_ram #(
    .DEPTH (MAX_RANGES),
    .WIDTH (2 * DW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  // incoming fields, high bits beyond the address width dropped
  logic [DW-1:0] in_addr;
  logic [DW-1:0] in_len;
  logic [DW:0]   in_end;
  logic          in_too_high;

  assign in_addr     = in_data.address[DW-1:0];
  assign in_len      = in_data.length[DW-1:0];
  assign in_end      = {1'b0, in_addr} + {1'b0, in_len};
  assign in_too_high = TOP_CHECK && in_end[DW] && (in_end[DW-1:0] != '0);

  // entry under test
  logic [DW-1:0] q_base;
  logic [DW-1:0] q_len;
  logic          lk_hit;
  logic          ins_below;
  logic          ins_clash_hi;
  logic          ins_clash_lo;
  logic [IW-1:0] lk_next;
  logic          full;

  assign q_base       = ram_q[2*DW-1:DW];
  assign q_len        = ram_q[DW-1:0];
  assign lk_hit       = (a_r >= q_base) && ((a_r - q_base) < q_len);
  assign ins_below    = a_r < q_base;
  assign ins_clash_hi = len_r > (q_base - a_r);
  assign ins_clash_lo = (a_r - q_base) < q_len;
  assign full         = (count_r == CW'(MAX_RANGES));
  assign lk_next      = ((CW'(cur_r) + CW'(1)) == count_r) ? '0 : IW'(CW'(cur_r) + CW'(1));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    last_hit_nxt  = last_hit_r;
    cur_nxt       = cur_r;
    pos_nxt       = pos_r;
    left_nxt      = left_r;
    a_nxt         = a_r;
    len_nxt       = len_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = {a_r, len_r};
    ram_raddr     = cur_r;

    // result register drains independently
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        ram_raddr = (in_data.command == CMD_LOOKUP) ? last_hit_r : '0;
        if (in_valid) begin
          a_nxt    = in_addr;
          len_nxt  = in_len;
          left_nxt = count_r;
          cur_nxt  = ram_raddr;
          if (in_data.command == CMD_LOOKUP) begin
            if (count_r == '0) begin
              res_nxt   = '{status: ST_MISS, default: '0};
              state_nxt = S_DONE;
            end else begin
              state_nxt = S_LOOK;
            end
          end else if (in_too_high) begin
            res_nxt   = '{status: ST_BAD, default: '0};
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_WRITE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end

      // lookup scan, wrapping from the hint
      S_LOOK: begin
        ram_raddr = lk_next;
        if (lk_hit) begin
          last_hit_nxt = cur_r;
          res_nxt      = '{status: ST_OK, entry_index: IDX_W'(cur_r),
                           entry_base: FIELD_W'(q_base), entry_length: FIELD_W'(q_len)};
          state_nxt    = S_DONE;
        end else if (left_r == CW'(1)) begin
          res_nxt   = '{status: ST_MISS, default: '0};
          state_nxt = S_DONE;
        end else begin
          cur_nxt  = lk_next;
          left_nxt = left_r - CW'(1);
        end
      end

      // insert scan for overlap and sorted position
      S_SCAN: begin
        ram_raddr = IW'(CW'(cur_r) + CW'(1));
        if (ins_below) begin
          if (ins_clash_hi) begin
            res_nxt   = '{status: ST_BAD, default: '0};
            state_nxt = S_DONE;
          end else if (full) begin
            res_nxt   = '{status: ST_FULL, default: '0};
            state_nxt = S_DONE;
          end else begin
            pos_nxt   = cur_r;
            ram_raddr = IW'(count_r - CW'(1));
            cur_nxt   = ram_raddr;
            state_nxt = S_SHIFT;
          end
        end else if (ins_clash_lo) begin
          res_nxt   = '{status: ST_BAD, default: '0};
          state_nxt = S_DONE;
        end else if (left_r == CW'(1)) begin
          if (full) begin
            res_nxt   = '{status: ST_FULL, default: '0};
            state_nxt = S_DONE;
          end else begin
            pos_nxt   = IW'(count_r);
            state_nxt = S_WRITE;
          end
        end else begin
          cur_nxt  = ram_raddr;
          left_nxt = left_r - CW'(1);
        end
      end

      // move entries up by one, from the top down to the insert position
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(CW'(cur_r) + CW'(1));
        ram_wdata = ram_q;
        ram_raddr = cur_r - IW'(1);
        if (cur_r == pos_r) begin
          state_nxt = S_WRITE;
        end else begin
          cur_nxt = ram_raddr;
        end
      end

      // place the new range, hint follows its entry
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_r;
        ram_wdata = {a_r, len_r};
        count_nxt = count_r + CW'(1);
        if ((count_r != '0) && (pos_r <= last_hit_r) &&
            ((CW'(last_hit_r) + CW'(1)) < CW'(MAX_RANGES))) begin
          last_hit_nxt = last_hit_r + IW'(1);
        end
        res_nxt   = '{status: ST_OK, entry_index: IDX_W'(pos_r),
                      entry_base: FIELD_W'(a_r), entry_length: FIELD_W'(len_r)};
        state_nxt = S_DONE;
      end

      // hand the result over once the output register is free
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      last_hit_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      last_hit_r  <= last_hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    pos_r      <= pos_nxt;
    left_r     <= left_nxt;
    a_r        <= a_nxt;
    len_r      <= len_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // table never holds more than its depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_RANGES))
    else $error("range count above table depth");

  // hint always names a live entry
  a_hint_live: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0) |-> (CW'(last_hit_r) < count_r))
    else $error("last-hit hint outside filled entries");

  // count grows by at most one per insert and never shrinks
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((count_r == $past(count_r)) ||
                      (count_r == $past(count_r) + CW'(1))))
    else $error("range count changed by more than one");

  // shift never runs below the insert position
  a_shift_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> ((cur_r >= pos_r) && (CW'(cur_r) < count_r)))
    else $error("shift index outside the moving span");

endmodule

`default_nettype wire

### tb/range_table_checker.sv
// ----------------------------------------------------------------------------
// range_table_checker: result prediction and comparison for the range table
// Watches both channels of the core, keeps its own sorted range table with
// hint, works out the reply to each accepted command and compares every
// result transfer field by field against the oldest awaited reply.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module range_table_checker
  import art_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  input  wire logic      in_ready,
  input  wire in_item_t  in_data,
  input  wire logic      out_valid,
  input  wire logic      out_ready,
  input  wire out_item_t out_data,
  output int unsigned    mismatch_count,
  output int unsigned    awaited_count,
  output int unsigned    checked_count,
  output int unsigned    hit_count,
  output int unsigned    added_count,
  output int unsigned    refused_count
);

  // the core is built at its default 32-bit address width
  localparam int DEPTH = DEF_MAX_RANGES;

  // shadow table, sorted by base
  logic [FIELD_W-1:0] shadow_base [DEPTH];
  logic [FIELD_W-1:0] shadow_len  [DEPTH];
  int                 shadow_used;
  int                 shadow_hint;

  out_item_t   awaited_replies [$];
  int unsigned mismatches;
  int unsigned checked;
  int unsigned hits;
  int unsigned added;
  int unsigned refused;

  // one line per mismatch, printing capped to keep the log short
  task automatic report_mismatch(input string what, input logic [FIELD_W-1:0] got,
                                 input logic [FIELD_W-1:0] want);
    if (mismatches < 40)
      $display("mismatch at result %0d: %s got %h want %h", checked, what, got, want);
    mismatches++;
  endtask

  // first range that holds the address; a hit moves the hint
  task automatic predict_lookup(input logic [FIELD_W-1:0] addr, output out_item_t reply);
    int i;
    reply = '0;
    reply.status = ST_MISS;
    for (i = 0; i < shadow_used; i++) begin
      if (addr >= shadow_base[i] && addr - shadow_base[i] < shadow_len[i]) begin
        shadow_hint = i;
        reply.status       = ST_OK;
        reply.entry_index  = IDX_W'(i);
        reply.entry_base   = shadow_base[i];
        reply.entry_length = shadow_len[i];
        break;
      end
    end
  endtask

  // sorted insert: top-of-space check, then overlap, then table full
  task automatic predict_insert(input logic [FIELD_W-1:0] base, input logic [FIELD_W-1:0] len,
                                output out_item_t reply);
    int   pos;
    int   i;
    logic clash;
    reply = '0;
    pos   = shadow_used;
    clash = 1'b0;
    if (len != '0 && len - 1 > ~base) begin
      // range would run past the top of the address space
      clash = 1'b1;
    end else begin
      for (i = 0; i < shadow_used; i++) begin
        if (base < shadow_base[i]) begin
          if (len > shadow_base[i] - base) clash = 1'b1;
          pos = i;
          break;
        end
        if (base - shadow_base[i] < shadow_len[i]) begin
          clash = 1'b1;
          break;
        end
      end
    end
    if (clash) begin
      reply.status = ST_BAD;
    end else if (shadow_used >= DEPTH) begin
      reply.status = ST_FULL;
    end else begin
      // open a slot at the sorted position
      for (i = shadow_used; i > pos; i--) begin
        shadow_base[i] = shadow_base[i-1];
        shadow_len[i]  = shadow_len[i-1];
      end
      shadow_base[pos] = base;
      shadow_len[pos]  = len;
      // hint follows its entry when it shifts up
      if (shadow_used > 0 && pos <= shadow_hint && shadow_hint + 1 < DEPTH)
        shadow_hint++;
      shadow_used++;
      reply.status       = ST_OK;
      reply.entry_index  = IDX_W'(pos);
      reply.entry_base   = base;
      reply.entry_length = len;
    end
  endtask

  // compare result transfers first, then predict the accepted command
  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t fresh;
    if (!rst_n) begin
      shadow_used = 0;
      shadow_hint = 0;
      awaited_replies.delete();
      mismatches = 0;
      checked    = 0;
      hits       = 0;
      added      = 0;
      refused    = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("result with nothing awaited", out_data.entry_base, '0);
        end else begin
          want = awaited_replies.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", FIELD_W'(out_data.status), FIELD_W'(want.status));
          if (out_data.entry_index !== want.entry_index)
            report_mismatch("entry_index", FIELD_W'(out_data.entry_index),
                            FIELD_W'(want.entry_index));
          if (out_data.entry_base !== want.entry_base)
            report_mismatch("entry_base", out_data.entry_base, want.entry_base);
          if (out_data.entry_length !== want.entry_length)
            report_mismatch("entry_length", out_data.entry_length, want.entry_length);
          checked++;
        end
      end
      if (in_valid && in_ready) begin
        if (in_data.command == CMD_LOOKUP) begin
          predict_lookup(in_data.address, fresh);
          if (fresh.status == ST_OK) hits++;
        end else begin
          predict_insert(in_data.address, in_data.length, fresh);
          if (fresh.status == ST_OK) added++;
          else refused++;
        end
        awaited_replies.push_back(fresh);
      end
    end
    mismatch_count <= mismatches;
    awaited_count  <= awaited_replies.size();
    checked_count  <= checked;
    hit_count      <= hits;
    added_count    <= added;
    refused_count  <= refused;
  end

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench for the address range table core
// Sends a directed set of lookups and inserts around the edges of the address
// space, then random commands partly aimed at offered ranges, with random
// stalls on both channels; the checker beside the core judges every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import art_pkg::*;

  localparam int RANDOM_ITEMS = 1330;
  localparam int CALM_ITEMS   = 200;
  localparam int SEEN_DEPTH   = 48;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 60;

  logic      clk      = 1'b0;
  logic      rst_n    = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data  = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic        calm = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned lookups_sent = 0;
  int unsigned inserts_sent = 0;

  int unsigned mismatch_count;
  int unsigned awaited_count;
  int unsigned checked_count;
  int unsigned hit_count;
  int unsigned added_count;
  int unsigned refused_count;

  // ranges offered so far, used to aim later commands
  logic [FIELD_W-1:0] seen_base [$];
  logic [FIELD_W-1:0] seen_len  [$];

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  address_range_table_core DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  range_table_checker u_range_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data        (in_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_data       (out_data),
    .mismatch_count (mismatch_count),
    .awaited_count  (awaited_count),
    .checked_count  (checked_count),
    .hit_count      (hit_count),
    .added_count    (added_count),
    .refused_count  (refused_count)
  );

  // cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("tb_top: errors");
    $finish;
  end

  // result side back-pressure in bursts, none in the calm tail
  initial begin : sink_side
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat (calm ? 1 : $urandom_range(1, 30)) @(posedge clk);
      end
    end
  end

  // one command transfer, then perhaps a gap
  task automatic send_op(input logic cmd, input logic [FIELD_W-1:0] addr,
                         input logic [FIELD_W-1:0] len);
    in_item_t item;
    item.command = cmd;
    item.address = addr;
    item.length  = len;
    if (cmd == CMD_INSERT) begin
      seen_base.push_back(addr);
      seen_len.push_back(len);
      if (seen_base.size() > SEEN_DEPTH) begin
        void'(seen_base.pop_front());
        void'(seen_len.pop_front());
      end
      inserts_sent++;
    end else begin
      lookups_sent++;
    end
    in_data  <= item;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  // lookup aimed at the edges of an offered range, or anywhere
  function automatic in_item_t make_lookup();
    in_item_t           item;
    int unsigned        k;
    logic [FIELD_W-1:0] b;
    logic [FIELD_W-1:0] l;
    item.command = CMD_LOOKUP;
    item.length  = $urandom;
    item.address = $urandom;
    if (seen_base.size() != 0 && $urandom_range(0, 1) == 0) begin
      k = $urandom_range(0, seen_base.size() - 1);
      b = seen_base[k];
      l = seen_len[k];
      case ($urandom_range(0, 4))
        0:       item.address = b;
        1:       item.address = b + l - 1;
        2:       item.address = b + l;
        3:       item.address = b - 1;
        default: item.address = b + ((l == '0) ? '0 : $urandom_range(0, l - 1));
      endcase
    end else if ($urandom_range(0, 4) == 0) begin
      case ($urandom_range(0, 3))
        0:       item.address = '0;
        1:       item.address = '1;
        2:       item.address = 32'h8000_0000;
        default: item.address = 32'h7FFF_FFFF;
      endcase
    end
    return item;
  endfunction

  // insert: mostly short ranges, some abutting or overlapping offered ones
  function automatic in_item_t make_insert();
    in_item_t    item;
    int unsigned k;
    int unsigned pick;
    item.command = CMD_INSERT;
    item.address = $urandom;
    item.length  = $urandom_range(0, 32'd1 << $urandom_range(0, 20));
    k    = (seen_base.size() == 0) ? 0 : $urandom_range(0, seen_base.size() - 1);
    pick = (seen_base.size() == 0) ? 0 : $urandom_range(0, 9);
    case (pick)
      0, 1, 2, 3: ;
      4, 5:    item.address = seen_base[k] + seen_len[k];
      6:       item.address = seen_base[k] + $urandom_range(0, 15);
      7:       item.address = seen_base[k] - item.length;
      8:       item.address = 32'hFFFF_FFFF - $urandom_range(0, 64);
      default: item.length  = $urandom;
    endcase
    return item;
  endfunction

  initial begin : stimulus
    int       n;
    in_item_t item;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty table misses
    send_op(CMD_LOOKUP, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // range ending exactly at the top, then one past it
    send_op(CMD_INSERT, 32'hFFFF_FFF0, 32'h0000_0010);
    send_op(CMD_INSERT, 32'hFFFF_FFFF, 32'h0000_0002);
    // full-width length overlapping the top range
    send_op(CMD_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
    // zero-length ranges
    send_op(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_INSERT, 32'h0000_1000, 32'h0000_0000);
    send_op(CMD_LOOKUP, 32'h0000_1000, 32'h0000_0000);
    send_op(CMD_INSERT, 32'h0000_1000, 32'h0000_0100);
    send_op(CMD_LOOKUP, 32'h0000_10FF, 32'h0000_0000);
    send_op(CMD_LOOKUP, 32'h0000_1100, 32'h0000_0000);
    // overlap inside, overlap into the next range, then abutting below
    send_op(CMD_INSERT, 32'h0000_1080, 32'h0000_0010);
    send_op(CMD_INSERT, 32'h0000_0F00, 32'h0000_0101);
    send_op(CMD_INSERT, 32'h0000_0F00, 32'h0000_0100);
    send_op(CMD_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000);
    send_op(CMD_LOOKUP, 32'hFFFF_FFF0, 32'h0000_0000);
    send_op(CMD_LOOKUP, 32'hFFFF_FFEF, 32'h0000_0000);
    send_op(CMD_LOOKUP, 32'h0000_0F00, 32'h0000_0000);
    // second zero-length range on the same base
    send_op(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
    send_op(CMD_INSERT, 32'hFFFF_FFF0, 32'h0000_0000);
    // half the space: passes the top check, overlaps the top range
    send_op(CMD_INSERT, 32'h8000_0000, 32'h8000_0000);
    send_op(CMD_INSERT, 32'h7FFF_FFFF, 32'h0000_0001);
    send_op(CMD_LOOKUP, 32'h7FFF_FFFF, 32'h0000_0000);

    // random command streams, the tail without stalls
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm <= 1'b1;
      if ($urandom_range(0, 99) < 55) item = make_lookup();
      else item = make_insert();
      send_op(item.command, item.address, item.length);
    end
    in_valid <= 1'b0;

    // drain
    @(posedge clk);
    while (awaited_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d lookups and %0d inserts sent, %0d results compared",
             lookups_sent, inserts_sent, checked_count);
    $display("summary: %0d lookup hits, %0d ranges stored, %0d inserts refused",
             hit_count, added_count, refused_count);
    if (mismatch_count == 0 && awaited_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/art_pkg.sv
rtl/core/art_ram.sv
rtl/core/address_range_table_core.sv
tb/range_table_checker.sv
tb/tb_top.sv
